// File: src/morse_code_keyer_core_assert.svh
// Assertion macros for the Morse keyer checker.
// No dependencies; pulled in by the checker file.
`ifndef MORSE_CODE_KEYER_CORE_ASSERT_SVH
`define MORSE_CODE_KEYER_CORE_ASSERT_SVH

// overlapping implication, held off while rst is high
`define MCK_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("morse keyer check failed");

// next-cycle implication, held off while rst is high
`define MCK_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("morse keyer check failed");

`endif

// File: src/mck_pkg.sv
// Package for the Morse keyer: sequencer states, code table, constants.
// No dependencies.
`default_nettype none

package mck_pkg;

  localparam int UNIT_W = 16;
  localparam int DUR_W  = 19;
  localparam int UNITS_W = 3;
  localparam int ELEM_MAX = 5;
  localparam int IDX_W = 3;

  localparam logic [UNIT_W-1:0] UNIT_TICKS_RST = 16'd100;

  localparam logic [UNITS_W-1:0] UNITS_DOT  = 3'd1;
  localparam logic [UNITS_W-1:0] UNITS_DASH = 3'd3;
  localparam logic [UNITS_W-1:0] UNITS_LGAP = 3'd3;
  localparam logic [UNITS_W-1:0] UNITS_WGAP = 3'd7;

  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_D0    = 8'h30;
  localparam logic [7:0] CH_D9    = 8'h39;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ON,
    S_OFF,
    S_GAP
  } mck_state_t;

  // bit i set = element i is a dash, first element in bit 0
  typedef struct packed {
    logic             ok;
    logic [IDX_W-1:0] len;
    logic [ELEM_MAX-1:0] bits;
  } mck_code_t;

  function automatic mck_code_t letter_code(input logic [4:0] n);
    mck_code_t r;
    r.ok = 1'b1;
    case (n)
      5'd0:  begin r.len = 3'd2; r.bits = 5'b00010; end
      5'd1:  begin r.len = 3'd4; r.bits = 5'b00001; end
      5'd2:  begin r.len = 3'd4; r.bits = 5'b00101; end
      5'd3:  begin r.len = 3'd3; r.bits = 5'b00001; end
      5'd4:  begin r.len = 3'd1; r.bits = 5'b00000; end
      5'd5:  begin r.len = 3'd4; r.bits = 5'b00100; end
      5'd6:  begin r.len = 3'd3; r.bits = 5'b00011; end
      5'd7:  begin r.len = 3'd4; r.bits = 5'b00000; end
      5'd8:  begin r.len = 3'd2; r.bits = 5'b00000; end
      5'd9:  begin r.len = 3'd4; r.bits = 5'b01110; end
      5'd10: begin r.len = 3'd3; r.bits = 5'b00101; end
      5'd11: begin r.len = 3'd4; r.bits = 5'b00010; end
      5'd12: begin r.len = 3'd2; r.bits = 5'b00011; end
      5'd13: begin r.len = 3'd2; r.bits = 5'b00001; end
      5'd14: begin r.len = 3'd3; r.bits = 5'b00111; end
      5'd15: begin r.len = 3'd4; r.bits = 5'b00110; end
      5'd16: begin r.len = 3'd4; r.bits = 5'b01011; end
      5'd17: begin r.len = 3'd3; r.bits = 5'b00010; end
      5'd18: begin r.len = 3'd3; r.bits = 5'b00000; end
      5'd19: begin r.len = 3'd1; r.bits = 5'b00001; end
      5'd20: begin r.len = 3'd3; r.bits = 5'b00100; end
      5'd21: begin r.len = 3'd4; r.bits = 5'b01000; end
      5'd22: begin r.len = 3'd3; r.bits = 5'b00110; end
      5'd23: begin r.len = 3'd4; r.bits = 5'b01001; end
      5'd24: begin r.len = 3'd4; r.bits = 5'b01101; end
      5'd25: begin r.len = 3'd4; r.bits = 5'b00011; end
      default: begin r.ok = 1'b0; r.len = 3'd0; r.bits = 5'b00000; end
    endcase
    return r;
  endfunction

  function automatic mck_code_t digit_code(input logic [3:0] n);
    mck_code_t r;
    r.ok = 1'b1;
    r.len = 3'd5;
    case (n)
      4'd0: r.bits = 5'b11111;
      4'd1: r.bits = 5'b11110;
      4'd2: r.bits = 5'b11100;
      4'd3: r.bits = 5'b11000;
      4'd4: r.bits = 5'b10000;
      4'd5: r.bits = 5'b00000;
      4'd6: r.bits = 5'b00001;
      4'd7: r.bits = 5'b00011;
      4'd8: r.bits = 5'b00111;
      4'd9: r.bits = 5'b01111;
      default: begin r.ok = 1'b0; r.len = 3'd0; r.bits = 5'b00000; end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: src/mck_scale.sv
// Shared duration unit: units (1, 3 or 7) times unit_ticks by shift and add.
// Depends on mck_pkg.
`default_nettype none

module mck_scale
  import mck_pkg::*;
(
  input  logic [UNITS_W-1:0] units,
  input  logic [UNIT_W-1:0]  unit_ticks,
  output logic [DUR_W-1:0]   duration
);

  logic [DUR_W-1:0] u;

  assign u = DUR_W'(unit_ticks);

  always_comb begin
    duration = (units[0] ? u : '0)
             + (units[1] ? (u << 1) : '0)
             + (units[2] ? (u << 2) : '0);
  end

endmodule

`default_nettype wire

// File: src/mck_seq.sv
// Element sequencer and output register for the Morse keyer.
// Depends on mck_pkg; drives the shared duration unit mck_scale.
`default_nettype none

module mck_seq
  import mck_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         character,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               led_on,
  output logic [DUR_W-1:0]   duration_ticks,
  output logic               last,
  output logic [UNITS_W-1:0] units,
  input  logic [DUR_W-1:0]   duration
);

  mck_state_t state, state_next;
  logic [IDX_W-1:0]    idx, idx_next;
  logic [IDX_W-1:0]    len;
  logic [ELEM_MAX-1:0] bits;
  logic                gap;
  logic                space;

  mck_code_t code;
  logic      in_acc;
  logic      out_free;
  logic      emit;
  logic      seg_led;
  logic      seg_last;
  logic      final_elem;

  assign in_ready   = (state == S_IDLE);
  assign in_acc     = in_valid && in_ready;
  assign out_free   = !out_valid || out_ready;
  assign final_elem = (idx == len - 3'd1);

  always_comb begin
    code = '0;
    if (character >= CH_UA && character <= CH_UZ) begin
      code = letter_code(5'(character - CH_UA));
    end else if (character >= CH_LA && character <= CH_LZ) begin
      code = letter_code(5'(character - CH_LA));
    end else if (character >= CH_D0 && character <= CH_D9) begin
      code = digit_code(4'(character - CH_D0));
    end else if (character == CH_DOT || character == CH_DASH) begin
      code.ok   = 1'b1;
      code.len  = 3'd1;
      code.bits = {4'b0000, character == CH_DASH};
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    emit       = 1'b0;
    seg_led    = 1'b0;
    seg_last   = 1'b0;
    units      = UNITS_DOT;
    case (state)
      S_IDLE: begin
        idx_next = '0;
        if (in_acc) begin
          if (character == CH_SPACE) begin
            state_next = S_GAP;
          end else if (code.ok) begin
            state_next = S_ON;
          end
        end
      end
      S_ON: begin
        seg_led = 1'b1;
        units   = bits[idx] ? UNITS_DASH : UNITS_DOT;
        if (out_free) begin
          emit       = 1'b1;
          state_next = S_OFF;
        end
      end
      S_OFF: begin
        units    = UNITS_DOT;
        seg_last = final_elem && !gap;
        if (out_free) begin
          emit = 1'b1;
          if (final_elem) begin
            state_next = gap ? S_GAP : S_IDLE;
          end else begin
            idx_next   = idx + 3'd1;
            state_next = S_ON;
          end
        end
      end
      S_GAP: begin
        units    = space ? UNITS_WGAP : UNITS_LGAP;
        seg_last = 1'b1;
        if (out_free) begin
          emit       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      len   <= code.len;
      bits  <= code.bits;
      space <= (character == CH_SPACE);
      gap   <= (character != CH_DOT) && (character != CH_DASH);
    end
    if (emit) begin
      led_on         <= seg_led;
      duration_ticks <= duration;
      last           <= seg_last;
    end
  end

endmodule

`default_nettype wire

// File: src/morse_code_keyer_core.sv
// Morse keyer top level: unit length register, sequencer, duration unit.
// Depends on mck_pkg, mck_seq and mck_scale.
//
//   channel  signals                          direction  payload
//   in       in_valid / in_ready              request in  character
//   out      out_valid / out_ready            request out led_on, duration_ticks, last
//   cfg      cfg_wr_en / cfg_wr_data          write in    unit_ticks
//
// A character is accepted, then keyed as segments: lit and dark per element
// plus the letter gap; '.' and '-' have no letter gap, space sends only the
// word gap, any other code sends nothing. Segments leave one per cycle, while
// the output is not stalled, through the single output register, each scaled
// by the shared shift-add unit. A stalled output holds the sequencer. Reset is synchronous; unit_ticks returns to 100.
`default_nettype none

module morse_code_keyer_core
  import mck_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         character,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               led_on,
  output logic [DUR_W-1:0]   duration_ticks,
  output logic               last,
  input  logic               cfg_wr_en,
  input  logic [UNIT_W-1:0]  cfg_wr_data
);

  logic [UNIT_W-1:0]  unit_ticks;
  logic [UNITS_W-1:0] units;
  logic [DUR_W-1:0]   duration;

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_ticks <= UNIT_TICKS_RST;
    end else if (cfg_wr_en) begin
      unit_ticks <= cfg_wr_data;
    end
  end

  mck_scale u_scale (
    .units      (units),
    .unit_ticks (unit_ticks),
    .duration   (duration)
  );

  mck_seq u_seq (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .character      (character),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .led_on         (led_on),
    .duration_ticks (duration_ticks),
    .last           (last),
    .units          (units),
    .duration       (duration)
  );

endmodule

`default_nettype wire

// File: src/mck_checker.sv
// Port-level checks for the Morse keyer, bound to morse_code_keyer_core.
// Depends on mck_pkg and morse_code_keyer_core_assert.svh.
`default_nettype none

`include "morse_code_keyer_core_assert.svh"

module mck_checker
  import mck_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic [7:0]       character,
  input logic             out_valid,
  input logic             out_ready,
  input logic             led_on,
  input logic [DUR_W-1:0] duration_ticks,
  input logic             last,
  input logic             cfg_wr_en,
  input logic [UNIT_W-1:0] cfg_wr_data
);

  logic unused_ok;
  assign unused_ok = &{1'b0, in_valid, character, cfg_wr_en, cfg_wr_data};

  `MCK_ASSERT_NEXT(a_rst_empty, clk, 1'b0, rst, !out_valid && in_ready)

  `MCK_ASSERT_IMPL(a_lit_not_last, clk, rst, out_valid && led_on, !last)

  `MCK_ASSERT_IMPL(a_busy_mid_char, clk, rst, out_valid && !last, !in_ready)

  `MCK_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready,
    out_valid && $stable(led_on) && $stable(duration_ticks) && $stable(last))

endmodule

bind morse_code_keyer_core mck_checker u_mck_checker (.*);

`default_nettype wire

// File: tb/tb_morse_code_keyer_core.sv
// Self-checking testbench for morse_code_keyer_core: a directed table, then random
// characters over several unit lengths, checked segment by segment against a local predictor.
// Depends on mck_pkg and the keyer RTL only.
`timescale 1ns / 1ps

module tb_morse_code_keyer_core;
  import mck_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_SETTLE = 16;
  localparam int LONG_HOLD = 300;
  localparam int PHASES = 6;
  localparam int ITEMS_PER_PHASE = 31;
  localparam int DIRECTED_N = 25;

  typedef struct packed {
    logic             led;
    logic [DUR_W-1:0] dur;
    logic             last;
  } segment_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       typed;
    logic [1:0] n;
    segment_t   s0;
    segment_t   s1;
    segment_t   s2;
  } stim_row_t;

  localparam segment_t NO_SEG = '0;

  // typed rows assume the reset unit length of 100 ticks
  stim_row_t directed [DIRECTED_N] = '{
    '{8'h00, 1'b1, 2'd0, NO_SEG, NO_SEG, NO_SEG},
    '{8'hFF, 1'b1, 2'd0, NO_SEG, NO_SEG, NO_SEG},
    '{8'h23, 1'b1, 2'd0, NO_SEG, NO_SEG, NO_SEG},
    '{"E", 1'b1, 2'd3, '{1'b1, 19'd100, 1'b0}, '{1'b0, 19'd100, 1'b0},
      '{1'b0, 19'd300, 1'b1}},
    '{"T", 1'b1, 2'd3, '{1'b1, 19'd300, 1'b0}, '{1'b0, 19'd100, 1'b0},
      '{1'b0, 19'd300, 1'b1}},
    '{" ", 1'b1, 2'd1, '{1'b0, 19'd700, 1'b1}, NO_SEG, NO_SEG},
    '{".", 1'b1, 2'd2, '{1'b1, 19'd100, 1'b0}, '{1'b0, 19'd100, 1'b1}, NO_SEG},
    '{"-", 1'b1, 2'd2, '{1'b1, 19'd300, 1'b0}, '{1'b0, 19'd100, 1'b1}, NO_SEG},
    '{"A", 1'b0, 2'd0, NO_SEG, NO_SEG, NO_SEG},
    '{"Z", 1'b0, 2'd0, NO_SEG, NO_SEG, NO_SEG},
    '{"a", 1'b0, 2'd0, NO_SEG, NO_SEG, NO_SEG},
    '{"z", 1'b0, 2'd0, NO_SEG, NO_SEG, NO_SEG},
    '{"0", 1'b0, 2'd0, NO_SEG, NO_SEG, NO_SEG},
    '{"9", 1'b0, 2'd0, NO_SEG, NO_SEG, NO_SEG},
    '{"5", 1'b0, 2'd0, NO_SEG, NO_SEG, NO_SEG},
    '{"Q", 1'b0, 2'd0, NO_SEG, NO_SEG, NO_SEG},
    '{"Y", 1'b0, 2'd0, NO_SEG, NO_SEG, NO_SEG},
    '{"J", 1'b0, 2'd0, NO_SEG, NO_SEG, NO_SEG},
    '{8'h40, 1'b0, 2'd0, NO_SEG, NO_SEG, NO_SEG},
    '{8'h5B, 1'b0, 2'd0, NO_SEG, NO_SEG, NO_SEG},
    '{8'h60, 1'b0, 2'd0, NO_SEG, NO_SEG, NO_SEG},
    '{8'h7B, 1'b0, 2'd0, NO_SEG, NO_SEG, NO_SEG},
    '{8'h2F, 1'b0, 2'd0, NO_SEG, NO_SEG, NO_SEG},
    '{8'h3A, 1'b0, 2'd0, NO_SEG, NO_SEG, NO_SEG},
    '{8'h80, 1'b0, 2'd0, NO_SEG, NO_SEG, NO_SEG}
  };

  string letter_table [26] = '{
    ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..",
    ".---", "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.",
    "...", "-", "..-", "...-", ".--", "-..-", "-.--", "--.."
  };

  string digit_table [10] = '{
    "-----", ".----", "..---", "...--", "....-",
    ".....", "-....", "--...", "---..", "----."
  };

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [7:0]        character = 8'h00;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              led_on;
  logic [DUR_W-1:0]  duration_ticks;
  logic              last;
  logic              cfg_wr_en = 1'b0;
  logic [UNIT_W-1:0] cfg_wr_data = '0;

  segment_t          pending_segments [$];
  segment_t          want;
  logic [UNIT_W-1:0] unit_len = UNIT_TICKS_RST;
  int                failures = 0;
  int                segments_checked = 0;
  int                chars_keyed = 0;
  int                chars_silent = 0;
  int                settings_used = 1;
  int                cycle_count = 0;
  int                burst_left = 0;
  bit                hold_req = 1'b0;
  bit                hold_done = 1'b0;
  int                hold_cnt = 0;
  int                stretch_left = 0;
  int                stall_pct = 0;

  morse_code_keyer_core dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .character      (character),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .led_on         (led_on),
    .duration_ticks (duration_ticks),
    .last           (last),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  always #5 clk = ~clk;

  function automatic void push_segment(input logic led, input logic [UNITS_W-1:0] units);
    segment_t s;
    s.led = led;
    s.dur = DUR_W'(int'(units) * int'(unit_len));
    s.last = 1'b0;
    pending_segments.push_back(s);
  endfunction

  // queues the segments one character should produce; returns how many
  function automatic int key_character(input logic [7:0] c);
    string code;
    bit    letter_gap;
    int    first;
    first = pending_segments.size();
    letter_gap = 1'b1;
    if (c == CH_SPACE) begin
      push_segment(1'b0, UNITS_WGAP);
    end else begin
      if (c == CH_DOT || c == CH_DASH) begin
        code = (c == CH_DOT) ? "." : "-";
        letter_gap = 1'b0;
      end else if (c >= CH_UA && c <= CH_UZ) begin
        code = letter_table[c - CH_UA];
      end else if (c >= CH_LA && c <= CH_LZ) begin
        code = letter_table[c - CH_LA];
      end else if (c >= CH_D0 && c <= CH_D9) begin
        code = digit_table[c - CH_D0];
      end else begin
        return 0;
      end
      for (int i = 0; i < code.len(); i++) begin
        push_segment(1'b1, (code[i] == CH_DASH) ? UNITS_DASH : UNITS_DOT);
        push_segment(1'b0, UNITS_DOT);
      end
      if (letter_gap) push_segment(1'b0, UNITS_LGAP);
    end
    pending_segments[pending_segments.size() - 1].last = 1'b1;
    return pending_segments.size() - first;
  endfunction

  function automatic logic [7:0] random_character();
    int r;
    r = $urandom_range(99);
    if (r < 25) return CH_UA + 8'($urandom_range(25));
    if (r < 45) return CH_LA + 8'($urandom_range(25));
    if (r < 60) return CH_D0 + 8'($urandom_range(9));
    if (r < 68) return CH_SPACE;
    if (r < 74) return CH_DOT;
    if (r < 80) return CH_DASH;
    return 8'($urandom_range(255));
  endfunction

  task automatic offer(input logic [7:0] c);
    @(negedge clk);
    in_valid = 1'b1;
    character = c;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      @(negedge clk) in_valid = 1'b0;
      repeat ($urandom_range(0, 10)) @(negedge clk);
      burst_left = ($urandom_range(3) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
    end
  endtask

  // only once the keyer has drained
  task automatic set_unit_length(input logic [UNIT_W-1:0] v);
    @(negedge clk) in_valid = 1'b0;
    while (pending_segments.size() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    unit_len = v;
    settings_used++;
  endtask

  // receiver: one long hold on request, otherwise stretches of varying stall rate
  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      if (hold_cnt < LONG_HOLD) begin
        out_ready = 1'b0;
        hold_cnt++;
      end else begin
        hold_done = 1'b1;
      end
    end else begin
      if (stretch_left == 0) begin
        stretch_left = $urandom_range(5, 60);
        case ($urandom_range(2))
          0: stall_pct = 0;
          1: stall_pct = 30;
          default: stall_pct = 70;
        endcase
      end
      stretch_left--;
      out_ready = ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_segments.size() == 0) begin
        $error("segment with none expected: led_on %0d duration_ticks %0d last %0d",
               led_on, duration_ticks, last);
        failures++;
      end else begin
        want = pending_segments.pop_front();
        segments_checked++;
        if (led_on !== want.led) begin
          $error("led_on: expected %0d, got %0d", want.led, led_on);
          failures++;
        end
        if (duration_ticks !== want.dur) begin
          $error("duration_ticks: expected %0d, got %0d", want.dur, duration_ticks);
          failures++;
        end
        if (last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles, %0d segments outstanding",
               cycle_count, pending_segments.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    logic [7:0] c;
    repeat (11) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    for (int i = 0; i < DIRECTED_N; i++) begin
      offer(directed[i].ch);
      if (directed[i].typed) begin
        if (directed[i].n >= 1) pending_segments.push_back(directed[i].s0);
        if (directed[i].n >= 2) pending_segments.push_back(directed[i].s1);
        if (directed[i].n >= 3) pending_segments.push_back(directed[i].s2);
        if (directed[i].n == 0) chars_silent++;
        else chars_keyed++;
      end else if (key_character(directed[i].ch) > 0) begin
        chars_keyed++;
      end else begin
        chars_silent++;
      end
      pace();
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        1: set_unit_length(16'd1);
        2: set_unit_length(16'hFFFF);
        3: set_unit_length(16'd0);
        4: set_unit_length(16'($urandom_range(2, 65534)));
        5: set_unit_length(16'($urandom_range(1, 9)));
        default: ;
      endcase
      // stall the output while requests keep coming
      if (p == 1) hold_req = 1'b1;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        c = random_character();
        offer(c);
        if (key_character(c) > 0) begin
          chars_keyed++;
        end else begin
          chars_silent++;
        end
        pace();
      end
    end

    @(negedge clk) in_valid = 1'b0;
    while (pending_segments.size() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);

    $display("Keyed %0d characters and %0d silent codes over %0d unit lengths (1, 65535, 0",
             chars_keyed, chars_silent, settings_used);
    $display("among them); %0d segments checked, %0d mismatches", segments_checked, failures);
    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/mck_pkg.sv
src/mck_scale.sv
src/mck_seq.sv
src/morse_code_keyer_core.sv
src/mck_checker.sv
tb/tb_morse_code_keyer_core.sv
